// File: design/pkt_pkg.sv
package pkt_pkg;

   // Field widths fixed by the item format
   localparam int OP_W       = 2;
   localparam int NUC_W      = 8;
   localparam int WEIGHT_W   = 32;
   localparam int ROW_FLD_W  = 5;
   localparam int KMER_FLD_W = 8;
   localparam int TALLY_W    = 48;
   localparam int POS_W      = 16;

   // Configuration port
   localparam int KLEN_W     = 3;
   localparam int ROWS_W     = 6;
   localparam int OFS_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] REG_KMER_LENGTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_ROWS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_OFFSET = 2'd2;

   localparam logic [KLEN_W-1:0] KMER_LENGTH_RST   = 3'd2;
   localparam logic [ROWS_W-1:0] WINDOW_ROWS_RST   = 6'd8;
   localparam logic [OFS_W-1:0]  WINDOW_OFFSET_RST = 6'd0;

   // Base characters
   localparam logic [NUC_W-1:0] ASCII_C = 8'h43;
   localparam logic [NUC_W-1:0] ASCII_G = 8'h47;
   localparam logic [NUC_W-1:0] ASCII_T = 8'h54;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef struct packed {
      logic [KLEN_W-1:0] kmer_length;
      logic [ROWS_W-1:0] window_rows;
      logic [OFS_W-1:0]  window_offset;
   } cfg_type;

   typedef struct packed {
      op_type                kind;
      logic [1:0]            base;
      logic [WEIGHT_W-1:0]   weight;
      logic                  start;
      logic [ROW_FLD_W-1:0]  read_row;
      logic [KMER_FLD_W-1:0] read_kmer;
      logic                  read_oob;
   } entry_type;

   typedef struct packed {
      logic clearing;
   } eng_status_type;

endpackage

// File: design/pkt_channels.sv
interface pkt_req_if;
   logic                            valid;
   logic                            ready;
   logic [pkt_pkg::OP_W-1:0]        operation;
   logic [pkt_pkg::NUC_W-1:0]       nucleotide;
   logic [pkt_pkg::WEIGHT_W-1:0]    weight;
   logic                            sequence_start;
   logic [pkt_pkg::ROW_FLD_W-1:0]   read_row;
   logic [pkt_pkg::KMER_FLD_W-1:0]  read_kmer;

   modport source (
      output valid, operation, nucleotide, weight, sequence_start, read_row, read_kmer,
      input  ready
   );
   modport sink (
      input  valid, operation, nucleotide, weight, sequence_start, read_row, read_kmer,
      output ready
   );
endinterface

interface pkt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pkt_pkg::TALLY_W-1:0]  tally_value;

   modport source (
      output valid, tally_value,
      input  ready
   );
   modport sink (
      input  valid, tally_value,
      output ready
   );
endinterface

// File: design/pkt_ram.sv
module pkt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/pkt_front.sv
module pkt_front #(
   parameter int MAX_K    = 4,
   parameter int MAX_ROWS = 32
) (
   pkt_req_if.sink                  req,
   input  logic                     queue_full,
   input  pkt_pkg::eng_status_type  status,
   output logic                     push,
   output pkt_pkg::entry_type       entry
);

   logic fire;

   assign req.ready = !queue_full && !status.clearing;
   assign fire      = req.valid && req.ready;

   always_comb begin
      entry.kind      = pkt_pkg::op_type'(req.operation);
      entry.weight    = req.weight;
      entry.start     = req.sequence_start;
      entry.read_row  = req.read_row;
      entry.read_kmer = req.read_kmer;
      entry.read_oob  = (32'(req.read_row) >= MAX_ROWS) ||
                        ((32'(req.read_kmer) >> (2 * MAX_K)) != 32'd0);

      case (req.nucleotide)
         pkt_pkg::ASCII_C: entry.base = pkt_pkg::BASE_C;
         pkt_pkg::ASCII_G: entry.base = pkt_pkg::BASE_G;
         pkt_pkg::ASCII_T: entry.base = pkt_pkg::BASE_T;
         default:          entry.base = pkt_pkg::BASE_A;
      endcase

      // drop the unused operation code at the door
      case (req.operation)
         pkt_pkg::OP_PUSH, pkt_pkg::OP_READ, pkt_pkg::OP_CLEAR: push = fire;
         default:                                               push = 1'b0;
      endcase
   end

endmodule

// File: design/pkt_queue.sv
module pkt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pkt_pkg::entry_type  entry_in,
   input  logic                pop,
   output pkt_pkg::entry_type  entry_out,
   output logic                full,
   output logic                empty
);

   localparam int DEPTH = pkt_pkg::QUEUE_DEPTH;
   localparam int AW    = pkt_pkg::QUEUE_AW;
   localparam int CW    = pkt_pkg::QUEUE_CW;

   pkt_pkg::entry_type slots_ff [DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign entry_out = slots_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + AW'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: design/pkt_engine.sv
module pkt_engine #(
   parameter int MAX_K    = 4,
   parameter int MAX_ROWS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pkt_pkg::cfg_type         cfg,
   input  logic                     q_empty,
   input  pkt_pkg::entry_type       q_entry,
   output logic                     q_pop,
   output pkt_pkg::eng_status_type  status,
   pkt_rsp_if.source                rsp
);

   localparam int KW     = 2 * MAX_K;
   localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int DD     = MAX_ROWS + MAX_K - 1;
   localparam int DAW    = (DD > 1) ? $clog2(DD) : 1;
   localparam int SW     = $clog2(DD + 1);
   localparam int KCW    = $clog2(MAX_K + 1);
   localparam int RCW    = $clog2(MAX_ROWS + 1);
   localparam int SAW    = RW + KW;
   localparam int SDEPTH = 1 << SAW;
   localparam int TW     = pkt_pkg::TALLY_W;
   localparam int WW     = pkt_pkg::WEIGHT_W;
   localparam int PW     = pkt_pkg::POS_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WREAD,
      ST_WCHK,
      ST_ROWS,
      ST_RDATA
   } state_type;

   state_type         state_ff, state_in;
   logic [KW-1:0]     shift_ff, shift_in;
   logic [RW-1:0]     rhead_ff, rhead_in;
   logic [DAW-1:0]    dhead_ff, dhead_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [WW-1:0]     w_ff, w_in;
   logic [RW-1:0]     j_ff, j_in;
   logic [RW-1:0]     ptr_ff, ptr_in;
   logic              issue_on_ff, issue_on_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [RW-1:0]     s1_row_ff, s1_row_in;
   logic              s2_valid_ff, s2_valid_in;
   logic [SAW-1:0]    s2_addr_ff, s2_addr_in;
   logic [SAW-1:0]    clr_addr_ff, clr_addr_in;
   logic              rd_oob_ff, rd_oob_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]     rsp_data_ff, rsp_data_in;

   // effective configuration
   logic [KCW-1:0]    k_eff;
   logic [RCW-1:0]    rows_eff;
   logic [SW-1:0]     span;
   logic [SW-1:0]     off_eff;
   logic [SW-1:0]     lag;
   logic [KW-1:0]     kmask;

   // push update
   logic [KW-1:0]     shift_base;
   logic [KW-1:0]     shift_new;
   logic [RW-1:0]     rhead_new;
   logic [DAW-1:0]    dhead_new;
   logic [PW-1:0]     pos_base;
   logic [PW-1:0]     pos_new;
   logic              eligible;
   logic [SW:0]       didx_sum;
   logic [DAW-1:0]    didx;
   logic [RCW:0]      start_sum;
   logic [RW-1:0]     start_ptr;
   logic [TW:0]       sum_wide;
   logic [TW-1:0]     sum_sat;

   // memory ports
   logic              ring_we, ring_re;
   logic [RW-1:0]     ring_waddr, ring_raddr;
   logic [KW-1:0]     ring_rdata;
   logic              delay_we, delay_re;
   logic [DAW-1:0]    delay_waddr, delay_raddr;
   logic [WW-1:0]     delay_rdata;
   logic              store_we, store_re;
   logic [SAW-1:0]    store_waddr, store_raddr;
   logic [TW-1:0]     store_wdata, store_rdata;

   always_comb begin
      if (cfg.kmer_length == '0) begin
         k_eff = KCW'(1);
      end else if (32'(cfg.kmer_length) > MAX_K) begin
         k_eff = KCW'(MAX_K);
      end else begin
         k_eff = KCW'(cfg.kmer_length);
      end
      if (cfg.window_rows == '0) begin
         rows_eff = RCW'(1);
      end else if (32'(cfg.window_rows) > MAX_ROWS) begin
         rows_eff = RCW'(MAX_ROWS);
      end else begin
         rows_eff = RCW'(cfg.window_rows);
      end
      span = SW'(rows_eff) + SW'(k_eff) - SW'(2);
      if (32'(cfg.window_offset) > 32'(span)) begin
         off_eff = span;
      end else begin
         off_eff = SW'(cfg.window_offset);
      end
      lag = span - off_eff;
      for (int i = 0; i < MAX_K; i++) begin
         kmask[2*i +: 2] = (i < int'(k_eff)) ? 2'b11 : 2'b00;
      end
   end

   always_comb begin
      shift_base = q_entry.start ? '0 : shift_ff;
      shift_new  = KW'({shift_base, q_entry.base}) & kmask;
      rhead_new  = (rhead_ff == RW'(MAX_ROWS - 1)) ? '0 : rhead_ff + RW'(1);
      dhead_new  = (dhead_ff == DAW'(DD - 1)) ? '0 : dhead_ff + DAW'(1);
      pos_base   = q_entry.start ? '0 : pos_ff;
      pos_new    = (pos_base == '1) ? pos_base : pos_base + PW'(1);
      eligible   = (32'(pos_new) > 32'(span));

      // weight taken lag pushes back from the newest
      didx_sum = (SW+1)'(dhead_ff) + (SW+1)'(DD) - (SW+1)'(lag);
      if (didx_sum >= (SW+1)'(DD)) begin
         didx = DAW'(didx_sum - (SW+1)'(DD));
      end else begin
         didx = DAW'(didx_sum);
      end

      // oldest k-mer of the window
      start_sum = (RCW+1)'(rhead_ff) + (RCW+1)'(MAX_ROWS) + (RCW+1)'(1) - (RCW+1)'(rows_eff);
      if (start_sum >= (RCW+1)'(MAX_ROWS)) begin
         start_ptr = RW'(start_sum - (RCW+1)'(MAX_ROWS));
      end else begin
         start_ptr = RW'(start_sum);
      end

      sum_wide = {1'b0, store_rdata} + (TW+1)'(w_ff);
      sum_sat  = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      rhead_in     = rhead_ff;
      dhead_in     = dhead_ff;
      pos_in       = pos_ff;
      w_in         = w_ff;
      j_in         = j_ff;
      ptr_in       = ptr_ff;
      issue_on_in  = issue_on_ff;
      s1_valid_in  = 1'b0;
      s1_row_in    = s1_row_ff;
      s2_valid_in  = 1'b0;
      s2_addr_in   = s2_addr_ff;
      clr_addr_in  = clr_addr_ff;
      rd_oob_in    = rd_oob_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      q_pop       = 1'b0;
      ring_we     = 1'b0;
      ring_waddr  = rhead_new;
      ring_re     = 1'b0;
      ring_raddr  = ptr_ff;
      delay_we    = 1'b0;
      delay_waddr = dhead_new;
      delay_re    = 1'b0;
      delay_raddr = didx;
      store_we    = 1'b0;
      store_waddr = s2_addr_ff;
      store_wdata = sum_sat;
      store_re    = 1'b0;
      store_raddr = {s1_row_ff, ring_rdata};

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            store_we    = 1'b1;
            store_waddr = clr_addr_ff;
            store_wdata = '0;
            if (clr_addr_ff == SAW'(SDEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + SAW'(1);
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_entry.kind)
                  pkt_pkg::OP_PUSH: begin
                     ring_we  = 1'b1;
                     delay_we = 1'b1;
                     shift_in = shift_new;
                     rhead_in = rhead_new;
                     dhead_in = dhead_new;
                     pos_in   = pos_new;
                     if (eligible) begin
                        state_in = ST_WREAD;
                     end
                  end
                  pkt_pkg::OP_READ: begin
                     store_re    = 1'b1;
                     store_raddr = {RW'(q_entry.read_row), KW'(q_entry.read_kmer)};
                     rd_oob_in   = q_entry.read_oob;
                     state_in    = ST_RDATA;
                  end
                  pkt_pkg::OP_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WREAD: begin
            delay_re = 1'b1;
            state_in = ST_WCHK;
         end
         ST_WCHK: begin
            if (delay_rdata == '0) begin
               state_in = ST_IDLE;
            end else begin
               w_in        = delay_rdata;
               j_in        = '0;
               ptr_in      = start_ptr;
               issue_on_in = 1'b1;
               state_in    = ST_ROWS;
            end
         end
         ST_ROWS: begin
            // issue ring read, then store read, then saturating write back
            if (issue_on_ff) begin
               ring_re     = 1'b1;
               s1_valid_in = 1'b1;
               s1_row_in   = j_ff;
               if (RCW'(j_ff) == rows_eff - RCW'(1)) begin
                  issue_on_in = 1'b0;
               end else begin
                  j_in   = j_ff + RW'(1);
                  ptr_in = (ptr_ff == RW'(MAX_ROWS - 1)) ? '0 : ptr_ff + RW'(1);
               end
            end
            if (s1_valid_ff) begin
               store_re    = 1'b1;
               s2_valid_in = 1'b1;
               s2_addr_in  = {s1_row_ff, ring_rdata};
            end
            if (s2_valid_ff) begin
               store_we = 1'b1;
            end
            if (!issue_on_ff && !s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_RDATA: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_oob_ff ? '0 : store_rdata;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         shift_ff     <= '0;
         rhead_ff     <= '0;
         dhead_ff     <= '0;
         pos_ff       <= '0;
         issue_on_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         rhead_ff     <= rhead_in;
         dhead_ff     <= dhead_in;
         pos_ff       <= pos_in;
         issue_on_ff  <= issue_on_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff        <= w_in;
      j_ff        <= j_in;
      ptr_ff      <= ptr_in;
      s1_row_ff   <= s1_row_in;
      s2_addr_ff  <= s2_addr_in;
      rd_oob_ff   <= rd_oob_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.tally_value = rsp_data_ff;

   pkt_ram #(.WIDTH(KW), .DEPTH(MAX_ROWS)) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (shift_new),
      .re    (ring_re),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   pkt_ram #(.WIDTH(WW), .DEPTH(DD)) u_delay (
      .clock (clock),
      .we    (delay_we),
      .waddr (delay_waddr),
      .wdata (q_entry.weight),
      .re    (delay_re),
      .raddr (delay_raddr),
      .rdata (delay_rdata)
   );

   pkt_ram #(.WIDTH(TW), .DEPTH(SDEPTH)) u_store (
      .clock (clock),
      .we    (store_we),
      .waddr (store_waddr),
      .wdata (store_wdata),
      .re    (store_re),
      .raddr (store_raddr),
      .rdata (store_rdata)
   );

endmodule

// File: design/positional_kmer_tally_unit.sv
// Positional k-mer tally.
// req_ch carries one transaction per operation: push a base with its Q16.16
// weight, read one stored sum, or clear the whole store. Only a read returns
// a transaction on rsp_ch (48-bit Q32.16 sum). csr_* writes k-mer length,
// window rows and window offset; write them only while the block is idle.
// A two-entry queue sits between the accepting front and the engine, so
// up to two transactions are taken while the engine is still busy.
// Engine work per transaction:
//   push, window not full or delayed weight zero: no tally update
//   push that tallies: one tally-memory read-modify-write per row,
//     pipelined through the k-mer ring and the store
//   read: store read into the output register, then held until taken
//   clear: sweeps all MAX_ROWS' * 4^MAX_K store entries (MAX_ROWS rounded
//     up to a power of two), one store entry a cycle.
// Reset runs the same clearing pass with req_ch.ready low. A stalled rsp_ch
// holds the result in the output register; the engine then waits on the
// next read while the queue keeps filling.
module positional_kmer_tally_unit #(
   parameter int MAX_K    = 4,
   parameter int MAX_ROWS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   pkt_req_if.sink                            req_ch,
   pkt_rsp_if.source                          rsp_ch,
   input  logic                               csr_write_en,
   input  logic [pkt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pkt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   pkt_pkg::cfg_type         cfg_ff, cfg_in;
   pkt_pkg::entry_type       front_entry, queue_entry;
   pkt_pkg::eng_status_type  eng_status;
   logic                     front_push;
   logic                     queue_pop;
   logic                     queue_full;
   logic                     queue_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            pkt_pkg::REG_KMER_LENGTH:   cfg_in.kmer_length   = csr_wdata[pkt_pkg::KLEN_W-1:0];
            pkt_pkg::REG_WINDOW_ROWS:   cfg_in.window_rows   = csr_wdata[pkt_pkg::ROWS_W-1:0];
            pkt_pkg::REG_WINDOW_OFFSET: cfg_in.window_offset = csr_wdata[pkt_pkg::OFS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kmer_length   <= pkt_pkg::KMER_LENGTH_RST;
         cfg_ff.window_rows   <= pkt_pkg::WINDOW_ROWS_RST;
         cfg_ff.window_offset <= pkt_pkg::WINDOW_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pkt_front #(.MAX_K(MAX_K), .MAX_ROWS(MAX_ROWS)) u_front (
      .req        (req_ch),
      .queue_full (queue_full),
      .status     (eng_status),
      .push       (front_push),
      .entry      (front_entry)
   );

   pkt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .entry_in  (front_entry),
      .pop       (queue_pop),
      .entry_out (queue_entry),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   pkt_engine #(.MAX_K(MAX_K), .MAX_ROWS(MAX_ROWS)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (queue_empty),
      .q_entry (queue_entry),
      .q_pop   (queue_pop),
      .status  (eng_status),
      .rsp     (rsp_ch)
   );

endmodule

// File: design/pkt_checker.sv
module pkt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [pkt_pkg::OP_W-1:0]      req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pkt_pkg::TALLY_W-1:0]   rsp_tally_value
);

   logic [2:0] pending_ff, pending_in;
   logic       read_fire;
   logic       rsp_fire;

   assign read_fire = req_valid && req_ready && (req_operation == pkt_pkg::OP_READ);
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (read_fire && !rsp_fire) begin
         pending_in = pending_ff + 3'd1;
      end else if (rsp_fire && !read_fire) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tally_value))
      else $error("result changed or dropped while stalled");

   // every result answers an earlier read
   a_rsp_has_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result without an outstanding read");

   // reads in flight never exceed queue plus engine plus output register
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd4)
      else $error("too many reads in flight");

   // store is being swept right after reset
   a_no_accept_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("transaction accepted during the reset clearing pass");

endmodule

bind positional_kmer_tally_unit pkt_checker u_pkt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_operation   (req_ch.operation),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_tally_value (rsp_ch.tally_value)
);
